FILE: rtl/dbcd_pkg.sv
`timescale 1ns / 1ps
package dbcd_pkg;

    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 64;
    localparam int CELLS    = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int CELL_W   = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] BLANK_CHAR  = 8'h20;
    localparam logic [7:0] RESET_WIDTH = 8'd80;
    localparam logic [6:0] RESET_HEIGHT = 7'd25;
    localparam logic [7:0] RESET_BLANK = 8'd0;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BLANK  = 2'd2;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_SCAN  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_WR_DONE   = 2'd0,
        KIND_WR_REJECT = 2'd1,
        KIND_SCAN_SAME = 2'd2,
        KIND_SCAN_DIFF = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ
    } back_state_t;

    typedef struct packed {
        op_t               op;
        logic              sel;
        logic              ok;
        logic [ADDR_W-1:0] addr;
        logic [6:0]        x;
        logic [5:0]        y;
        logic [CELL_W-1:0] data;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic clearing;
        logic busy_read;
    } back_stat_t;

endpackage

FILE: rtl/dbcd_ram.sv
`timescale 1ns / 1ps
module dbcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/dbcd_front.sv
`timescale 1ns / 1ps
module dbcd_front import dbcd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [6:0] cell_x,
    input  logic [5:0] cell_y,
    input  logic [7:0] cell_color,
    input  logic [7:0] cell_char,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       q_full,
    input  back_stat_t back_stat,
    output logic       push,
    output cmd_t       push_cmd,
    output logic [7:0] blank_color
);

    logic [7:0] width_reg;
    logic [6:0] height_reg;
    logic [7:0] blank_reg;
    logic [6:0] scan_col_reg, scan_col_next;
    logic [5:0] scan_row_reg, scan_row_next;
    logic       active_reg, active_next;

    logic [7:0]  w;
    logic [6:0]  h;
    logic [6:0]  col_a;
    logic [6:0]  row_a;
    logic        col_end, row_end;
    logic [13:0] wr_idx, sc_idx;
    logic        is_scan;

    assign cfg_ready   = 1'b1;
    assign blank_color = blank_reg;
    assign in_ready    = !q_full && !back_stat.clearing;
    assign push        = in_valid && in_ready;
    assign is_scan     = (op_t'(opcode) == OP_SCAN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            blank_reg  <= RESET_BLANK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data[6:0];
                CFG_BLANK:  blank_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == 8'd0)
            w = 8'd1;
        else if (width_reg > 8'(MAX_COLS))
            w = 8'(MAX_COLS);
        else
            w = width_reg;
        if (height_reg == 7'd0)
            h = 7'd1;
        else if (height_reg > 7'(MAX_ROWS))
            h = 7'(MAX_ROWS);
        else
            h = height_reg;
    end

    // fold the counter back into a shrunken frame
    always_comb
    begin
        col_a = scan_col_reg;
        row_a = {1'b0, scan_row_reg};
        if ({1'b0, col_a} >= w)
        begin
            col_a = 7'd0;
            row_a = row_a + 7'd1;
        end
        if (row_a >= h)
        begin
            row_a = 7'd0;
            col_a = 7'd0;
        end
        col_end = ({1'b0, col_a} + 8'd1) >= w;
        row_end = (row_a + 7'd1) >= h;
    end

    assign wr_idx = 14'(cell_y) * 14'(w) + 14'(cell_x);
    assign sc_idx = 14'(row_a) * 14'(w) + 14'(col_a);

    always_comb
    begin
        scan_col_next = scan_col_reg;
        scan_row_next = scan_row_reg;
        active_next   = active_reg;

        push_cmd.op   = op_t'(opcode);
        push_cmd.sel  = active_reg;
        push_cmd.data = {cell_color, cell_char};
        if (is_scan)
        begin
            push_cmd.ok   = 1'b1;
            push_cmd.addr = sc_idx[ADDR_W-1:0];
            push_cmd.x    = col_a;
            push_cmd.y    = row_a[5:0];
            push_cmd.last = col_end && row_end;
        end
        else
        begin
            push_cmd.ok   = ({1'b0, cell_x} < w) && ({1'b0, cell_y} < h);
            push_cmd.addr = wr_idx[ADDR_W-1:0];
            push_cmd.x    = 7'd0;
            push_cmd.y    = 6'd0;
            push_cmd.last = 1'b0;
        end

        if (push && is_scan)
        begin
            if (col_end)
            begin
                scan_col_next = 7'd0;
                if (row_end)
                begin
                    scan_row_next = 6'd0;
                    active_next   = !active_reg;
                end
                else
                begin
                    scan_row_next = 6'(row_a + 7'd1);
                end
            end
            else
            begin
                scan_col_next = col_a + 7'd1;
                scan_row_next = row_a[5:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_col_reg <= 7'd0;
            scan_row_reg <= 6'd0;
            active_reg   <= 1'b0;
        end
        else
        begin
            scan_col_reg <= scan_col_next;
            scan_row_reg <= scan_row_next;
            active_reg   <= active_next;
        end
    end

endmodule

FILE: rtl/dbcd_queue.sv
`timescale 1ns / 1ps
module dbcd_queue import dbcd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/dbcd_back.sv
`timescale 1ns / 1ps
module dbcd_back import dbcd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head_cmd,
    output logic       pop,
    input  logic [7:0] blank_color,
    output back_stat_t back_stat,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [6:0] change_x,
    output logic [5:0] change_y,
    output logic [7:0] change_color,
    output logic [7:0] change_char,
    output logic       scan_last
);

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    cmd_t              cmd_reg;
    logic              cmd_load;

    logic              out_valid_reg, out_valid_next;
    kind_t             kind_reg, kind_next;
    logic [6:0]        x_reg, x_next;
    logic [5:0]        y_reg, y_next;
    logic [7:0]        color_reg, color_next;
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;
    logic              out_load;

    logic              a_we, b_we;
    logic [ADDR_W-1:0] a_waddr, b_waddr;
    logic [CELL_W-1:0] a_wdata, b_wdata;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] a_rdata, b_rdata;
    logic [CELL_W-1:0] cur_cell, prev_cell;
    logic              slot_free;

    dbcd_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_store_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (a_rdata)
    );

    dbcd_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_store_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (b_rdata)
    );

    assign slot_free = !out_valid_reg || out_ready;
    assign cur_cell  = cmd_reg.sel ? b_rdata : a_rdata;
    assign prev_cell = cmd_reg.sel ? a_rdata : b_rdata;

    assign back_stat.clearing  = (state_reg == BK_CLEAR);
    assign back_stat.busy_read = (state_reg == BK_READ);

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pop          = 1'b0;
        cmd_load     = 1'b0;
        out_load     = 1'b0;
        a_we         = 1'b0;
        b_we         = 1'b0;
        a_waddr      = head_cmd.addr;
        b_waddr      = head_cmd.addr;
        a_wdata      = head_cmd.data;
        b_wdata      = head_cmd.data;
        rd_en        = 1'b0;
        rd_addr      = head_cmd.addr;
        kind_next    = KIND_WR_DONE;
        x_next       = 7'd0;
        y_next       = 6'd0;
        color_next   = 8'd0;
        char_next    = 8'd0;
        last_next    = 1'b0;

        unique case (state_reg)
            BK_CLEAR:
            begin
                // blank both stores with the reset color
                a_we    = 1'b1;
                b_we    = 1'b1;
                a_waddr = clr_cnt_reg;
                b_waddr = clr_cnt_reg;
                a_wdata = {RESET_BLANK, BLANK_CHAR};
                b_wdata = {RESET_BLANK, BLANK_CHAR};
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(CELLS-1))
                    state_next = BK_IDLE;
            end
            BK_IDLE:
            begin
                if (head_valid && slot_free)
                begin
                    pop = 1'b1;
                    if (head_cmd.op == OP_WRITE)
                    begin
                        a_we      = head_cmd.ok && !head_cmd.sel;
                        b_we      = head_cmd.ok && head_cmd.sel;
                        out_load  = 1'b1;
                        kind_next = head_cmd.ok ? KIND_WR_DONE : KIND_WR_REJECT;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        cmd_load   = 1'b1;
                        state_next = BK_READ;
                    end
                end
            end
            BK_READ:
            begin
                // clear the previous frame's cell, report the active one
                a_we     = cmd_reg.sel;
                b_we     = !cmd_reg.sel;
                a_waddr  = cmd_reg.addr;
                b_waddr  = cmd_reg.addr;
                a_wdata  = {blank_color, BLANK_CHAR};
                b_wdata  = {blank_color, BLANK_CHAR};
                out_load = 1'b1;
                x_next   = cmd_reg.x;
                y_next   = cmd_reg.y;
                last_next = cmd_reg.last;
                if (cur_cell != prev_cell)
                begin
                    kind_next  = KIND_SCAN_DIFF;
                    color_next = cur_cell[15:8];
                    char_next  = cur_cell[7:0];
                end
                else
                begin
                    kind_next = KIND_SCAN_SAME;
                end
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_load)
        begin
            cmd_reg <= head_cmd;
        end
        if (out_load)
        begin
            kind_reg  <= kind_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            color_reg <= color_next;
            char_reg  <= char_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign change_x     = x_reg;
    assign change_y     = y_reg;
    assign change_color = color_reg;
    assign change_char  = char_reg;
    assign scan_last    = last_reg;

endmodule

FILE: rtl/double_buffered_cell_diff_core.sv
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// in       in_valid / in_ready    opcode, cell_x, cell_y, cell_color, cell_char
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
// out      out_valid / out_ready  kind, change_x, change_y, change_color,
//                                 change_char, scan_last
//
// A write request is handled in the back end's idle state; a scan request also passes
// through a read state: the frame store read is registered, and the previous frame's cell is blanked the cycle after.
// After reset every cell of both stores is blanked; in_ready stays low
// meanwhile, configuration writes are taken.
// A two-entry queue parts the front from the back; the back stalls on a full
// output register, the front on a full queue.
module double_buffered_cell_diff_core import dbcd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [6:0] cell_x,
    input  logic [5:0] cell_y,
    input  logic [7:0] cell_color,
    input  logic [7:0] cell_char,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [6:0] change_x,
    output logic [5:0] change_y,
    output logic [7:0] change_color,
    output logic [7:0] change_char,
    output logic       scan_last
);

    logic       q_full;
    logic       push;
    cmd_t       push_cmd;
    logic       pop;
    logic       head_valid;
    cmd_t       head_cmd;
    logic [7:0] blank_color;
    back_stat_t back_stat;

    dbcd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_color  (cell_color),
        .cell_char   (cell_char),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .back_stat   (back_stat),
        .push        (push),
        .push_cmd    (push_cmd),
        .blank_color (blank_color)
    );

    dbcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    dbcd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .blank_color  (blank_color),
        .back_stat    (back_stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .change_x     (change_x),
        .change_y     (change_y),
        .change_color (change_color),
        .change_char  (change_char),
        .scan_last    (scan_last)
    );

`ifndef ASSERT_OFF
    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.clearing |-> !(in_valid && in_ready))
        else $error("input request taken during store clearing");

    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.busy_read |=> out_valid)
        else $error("scan read produced no result");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !in_ready)
        else $error("request taken while queue full");

    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (back_stat.busy_read || back_stat.clearing) |-> !pop)
        else $error("queue popped while back end busy");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import dbcd_pkg::*;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 216;
    localparam int SETTLE_CYCLES   = 16;
    localparam int CYCLE_LIMIT     = 400000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        kind_t      kind;
        logic [6:0] x;
        logic [5:0] y;
        logic [7:0] color;
        logic [7:0] ch;
        logic       last;
    } cell_report_t;

    class frame_diff_scoreboard;
        bit [15:0]    store_a [CELLS];
        bit [15:0]    store_b [CELLS];
        bit           active_b;
        int           scan_col;
        int           scan_row;
        int           width_reg;
        int           height_reg;
        logic [7:0]   blank_reg;
        cell_report_t pending_reports[$];
        int           mismatch_count;

        function new();
            for (int i = 0; i < CELLS; i++)
            begin
                store_a[i] = {RESET_BLANK, BLANK_CHAR};
                store_b[i] = {RESET_BLANK, BLANK_CHAR};
            end
            active_b       = 1'b0;
            scan_col       = 0;
            scan_row       = 0;
            width_reg      = RESET_WIDTH;
            height_reg     = RESET_HEIGHT;
            blank_reg      = RESET_BLANK;
            mismatch_count = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [7:0] data);
            case (idx)
                CFG_WIDTH:  width_reg = data;
                CFG_HEIGHT: height_reg = data[6:0];
                CFG_BLANK:  blank_reg = data;
                default:    ;
            endcase
        endfunction

        function void note_request(op_t op, logic [6:0] x, logic [5:0] y,
                                   logic [7:0] color, logic [7:0] ch);
            cell_report_t rpt;
            int           cols;
            int           rows;
            int           idx;
            bit [15:0]    now_cell;
            bit [15:0]    old_cell;
            cols = (width_reg == 0) ? 1 : (width_reg > MAX_COLS) ? MAX_COLS : width_reg;
            rows = (height_reg == 0) ? 1 : (height_reg > MAX_ROWS) ? MAX_ROWS : height_reg;
            rpt = '0;
            if (op == OP_WRITE)
            begin
                if (x < cols && y < rows)
                begin
                    idx = y * cols + x;
                    if (active_b)
                        store_b[idx] = {color, ch};
                    else
                        store_a[idx] = {color, ch};
                    rpt.kind = KIND_WR_DONE;
                end
                else
                begin
                    rpt.kind = KIND_WR_REJECT;
                end
            end
            else
            begin
                if (scan_col >= cols)
                begin
                    scan_col = 0;
                    scan_row++;
                end
                if (scan_row >= rows)
                begin
                    scan_row = 0;
                    scan_col = 0;
                end
                idx = scan_row * cols + scan_col;
                now_cell = active_b ? store_b[idx] : store_a[idx];
                old_cell = active_b ? store_a[idx] : store_b[idx];
                if (active_b)
                    store_a[idx] = {blank_reg, BLANK_CHAR};
                else
                    store_b[idx] = {blank_reg, BLANK_CHAR};
                rpt.x = 7'(scan_col);
                rpt.y = 6'(scan_row);
                if (now_cell != old_cell)
                begin
                    rpt.kind  = KIND_SCAN_DIFF;
                    rpt.color = now_cell[15:8];
                    rpt.ch    = now_cell[7:0];
                end
                else
                begin
                    rpt.kind = KIND_SCAN_SAME;
                end
                if (scan_col + 1 >= cols)
                begin
                    scan_col = 0;
                    if (scan_row + 1 >= rows)
                    begin
                        scan_row = 0;
                        rpt.last = 1'b1;
                        active_b = ~active_b;
                    end
                    else
                    begin
                        scan_row++;
                    end
                end
                else
                begin
                    scan_col++;
                end
            end
            pending_reports.push_back(rpt);
        endfunction

        function void check_result(cell_report_t got);
            cell_report_t want;
            if (pending_reports.size() == 0)
            begin
                $error("result with no request pending: kind %0d x %0d y %0d",
                       got.kind, got.x, got.y);
                mismatch_count++;
                return;
            end
            want = pending_reports.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                mismatch_count++;
            end
            if (got.x !== want.x)
            begin
                $error("change_x: expected %0d, got %0d", want.x, got.x);
                mismatch_count++;
            end
            if (got.y !== want.y)
            begin
                $error("change_y: expected %0d, got %0d", want.y, got.y);
                mismatch_count++;
            end
            if (got.color !== want.color)
            begin
                $error("change_color: expected %0d, got %0d", want.color, got.color);
                mismatch_count++;
            end
            if (got.ch !== want.ch)
            begin
                $error("change_char: expected %0d, got %0d", want.ch, got.ch);
                mismatch_count++;
            end
            if (got.last !== want.last)
            begin
                $error("scan_last: expected %0d, got %0d", want.last, got.last);
                mismatch_count++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       opcode;
    logic [6:0] cell_x;
    logic [5:0] cell_y;
    logic [7:0] cell_color;
    logic [7:0] cell_char;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] kind;
    logic [6:0] change_x;
    logic [5:0] change_y;
    logic [7:0] change_color;
    logic [7:0] change_char;
    logic       scan_last;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    frame_diff_scoreboard scoreboard = new();

    double_buffered_cell_diff_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .cell_color   (cell_color),
        .cell_char    (cell_char),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .change_x     (change_x),
        .change_y     (change_y),
        .change_color (change_color),
        .change_char  (change_char),
        .scan_last    (scan_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            scoreboard.check_result({kind, change_x, change_y, change_color,
                                     change_char, scan_last});
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_request(input op_t op, input logic [6:0] x, input logic [5:0] y,
                                input logic [7:0] color, input logic [7:0] ch);
        int gap_cycles;
        gap_cycles = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap_cycles++;
        @(negedge clk);
        if (gap_cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_cycles) @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        cell_x     <= x;
        cell_y     <= y;
        cell_color <= color;
        cell_char  <= ch;
        do @(posedge clk); while (!in_ready);
        scoreboard.note_request(op, x, y, color, ch);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        scoreboard.set_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // hold off new requests until every pending result is out and the back end is quiet
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (scoreboard.pending_reports.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int         cols;
        int         rows;
        int         pick;
        logic [7:0] phase_width;
        logic [7:0] phase_height;
        logic [7:0] phase_blank;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = OP_WRITE;
        cell_x     = '0;
        cell_y     = '0;
        cell_color = '0;
        cell_char  = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_WIDTH;
        cfg_data   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_request(OP_WRITE, 7'd79, 6'd24, 8'hFF, 8'hFF);
        send_request(OP_WRITE, 7'd80, 6'd0, 8'h11, 8'h22);
        send_request(OP_WRITE, 7'd0, 6'd25, 8'h33, 8'h44);
        send_request(OP_WRITE, 7'd127, 6'd63, 8'hFF, 8'hFF);
        send_request(OP_WRITE, 7'd0, 6'd0, 8'h00, 8'h00);
        send_request(OP_SCAN, 7'd0, 6'd0, 8'h00, 8'h00);
        send_request(OP_SCAN, 7'd127, 6'd63, 8'hFF, 8'hFF);

        // oversized frame clamps to the store size
        drain_results();
        write_register(CFG_WIDTH, 8'd255);
        write_register(CFG_HEIGHT, 8'd127);
        write_register(CFG_BLANK, 8'hFF);
        write_register(CFG_UNUSED, 8'hAA);
        send_request(OP_WRITE, 7'd127, 6'd63, 8'hAA, 8'h55);
        send_request(OP_SCAN, 7'd0, 6'd0, 8'h00, 8'h00);

        // shrink so the scan position falls outside the frame
        drain_results();
        write_register(CFG_WIDTH, 8'd2);
        write_register(CFG_HEIGHT, 8'd1);
        send_request(OP_SCAN, 7'd0, 6'd0, 8'h00, 8'h00);
        send_request(OP_SCAN, 7'd0, 6'd0, 8'h00, 8'h00);
        send_request(OP_WRITE, 7'd1, 6'd0, 8'h12, 8'h34);
        send_request(OP_SCAN, 7'd0, 6'd0, 8'h00, 8'h00);
        send_request(OP_SCAN, 7'd0, 6'd0, 8'h00, 8'h00);

        // zero size counts as one cell
        drain_results();
        write_register(CFG_WIDTH, 8'd0);
        write_register(CFG_HEIGHT, 8'd0);
        write_register(CFG_BLANK, 8'h00);
        send_request(OP_WRITE, 7'd1, 6'd0, 8'h01, 8'h02);
        send_request(OP_WRITE, 7'd0, 6'd1, 8'h03, 8'h04);
        send_request(OP_WRITE, 7'd0, 6'd0, 8'h7F, 8'h80);
        send_request(OP_SCAN, 7'd0, 6'd0, 8'h00, 8'h00);
        send_request(OP_SCAN, 7'd0, 6'd0, 8'h00, 8'h00);

        drain_results();
        write_register(CFG_WIDTH, 8'd128);
        write_register(CFG_HEIGHT, 8'd64);
        send_request(OP_WRITE, 7'd127, 6'd63, 8'h01, 8'hFE);
        send_request(OP_SCAN, 7'd0, 6'd0, 8'h00, 8'h00);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            phase_width  = 8'($urandom_range(0, 12));
            phase_height = 8'($urandom_range(0, 6));
            phase_blank  = 8'($urandom_range(0, 255));
            write_register(CFG_WIDTH, phase_width);
            write_register(CFG_HEIGHT, phase_height);
            write_register(CFG_BLANK, phase_blank);
            cols = (phase_width == 0) ? 1 : phase_width;
            rows = (phase_height == 0) ? 1 : phase_height;
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct  = 19;
                    recv_stall_pct = 19;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == ITEMS_PER_PHASE / 2)
                    drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    send_request(OP_SCAN, 7'($urandom), 6'($urandom),
                                 8'($urandom), 8'($urandom));
                else if (pick < 52)
                    send_request(OP_WRITE, 7'($urandom_range(0, cols - 1)),
                                 6'($urandom_range(0, rows - 1)), phase_blank, BLANK_CHAR);
                else if (pick < 90)
                    send_request(OP_WRITE, 7'($urandom_range(0, cols - 1)),
                                 6'($urandom_range(0, rows - 1)),
                                 8'($urandom), 8'($urandom));
                else
                    send_request(OP_WRITE, 7'($urandom), 6'($urandom),
                                 8'($urandom), 8'($urandom));
            end
        end

        drain_results();
        if (scoreboard.mismatch_count == 0 && scoreboard.pending_reports.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: double_buffered_cell_diff_core.f
rtl/dbcd_pkg.sv
rtl/dbcd_ram.sv
rtl/dbcd_front.sv
rtl/dbcd_queue.sv
rtl/dbcd_back.sv
rtl/double_buffered_cell_diff_core.sv
tb/testbench.sv
